/* hw/rtl/tlhg_pkg.sv */
// Shared types and constants for the tiered latency hysteresis guard.
// Used by every module of the block; depends on nothing.

package tlhg_pkg;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int SCALE_W    = 9;
  localparam int TIER_W     = 3;
  localparam int COUNT_W    = 32;
  localparam int SAMPLE_W   = 32;
  localparam int NUM_LEVELS = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_WARN     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THROTTLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DROP     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BREAKER  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE    = 3'd4;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] RST_WARN     = 32'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_THROTTLE = 32'd5000;
  localparam logic [CFG_DATA_W-1:0] RST_DROP     = 32'd10000;
  localparam logic [CFG_DATA_W-1:0] RST_BREAKER  = 32'd50000;
  localparam logic [SCALE_W-1:0]    RST_SCALE    = 9'd205;

  // Request operation codes.
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Tier codes.
  localparam logic [TIER_W-1:0] TIER_NORMAL   = 3'd0;
  localparam logic [TIER_W-1:0] TIER_WARN     = 3'd1;
  localparam logic [TIER_W-1:0] TIER_THROTTLE = 3'd2;
  localparam logic [TIER_W-1:0] TIER_DROP     = 3'd3;
  localparam logic [TIER_W-1:0] TIER_BREAKER  = 3'd4;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // A classified request as it travels from the front to the back part.
  // keep[i] is set when the sample is high enough to hold the tier of
  // thr[i] under the recovery scale, an unsigned fraction with 8 fraction bits.
  typedef struct packed {
    logic                  op;
    logic [TIER_W-1:0]     target;
    logic [NUM_LEVELS-1:0] keep;
  } tlhg_cmd_t;

endpackage

/* hw/rtl/tlhg_front.sv */
// Front part of the latency guard: registers an incoming request and
// classifies it against the thresholds. Depends on tlhg_pkg.

module tlhg_front import tlhg_pkg::*; #(
  parameter int LAT_W = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [LAT_W-1:0]                    in_lat,
  input  logic [NUM_LEVELS-1:0][LAT_W-1:0]    thr,
  input  logic [SCALE_W-1:0]                  scale,
  output logic                                q_valid,
  input  logic                                q_ready,
  output tlhg_cmd_t                           q_cmd
);

  localparam int PROD_W = LAT_W + SCALE_W;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             s1_op_r;
  logic [LAT_W-1:0] s1_lat_r;
  logic             advance;
  logic             take;
  logic [PROD_W-1:0] lat_scaled;
  logic [NUM_LEVELS-1:0][PROD_W-1:0] level_scaled;

  assign advance  = s1_valid_r && q_ready;
  assign in_ready = !s1_valid_r || q_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op_r  <= in_op;
      s1_lat_r <= in_lat;
    end
  end

  // One narrow multiply per level, all in parallel.
  assign lat_scaled = {1'b0, s1_lat_r, 8'b0};

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      level_scaled[i] = PROD_W'(thr[i]) * PROD_W'(scale);
    end
  end

  always_comb begin
    q_cmd.op = s1_op_r;
    if (s1_lat_r >= thr[3]) begin
      q_cmd.target = TIER_BREAKER;
    end else if (s1_lat_r >= thr[2]) begin
      q_cmd.target = TIER_DROP;
    end else if (s1_lat_r >= thr[1]) begin
      q_cmd.target = TIER_THROTTLE;
    end else if (s1_lat_r >= thr[0]) begin
      q_cmd.target = TIER_WARN;
    end else begin
      q_cmd.target = TIER_NORMAL;
    end
    for (int i = 0; i < NUM_LEVELS; i++) begin
      q_cmd.keep[i] = lat_scaled >= level_scaled[i];
    end
  end

  assign q_valid = s1_valid_r;

endmodule

/* hw/rtl/tlhg_queue.sv */
// Short queue of classified requests between the front and back parts.
// Depends on tlhg_pkg for the entry type and depth.

module tlhg_queue import tlhg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tlhg_cmd_t push_cmd,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output tlhg_cmd_t head_cmd
);

  tlhg_cmd_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;
  logic               do_wr;
  logic               do_rd;

  assign not_full  = count_r != Q_CNT_W'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign do_wr     = push && not_full;
  assign do_rd     = pop && not_empty;
  assign head_cmd  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  // A write without a read grows the fill count by exactly one.
  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on write");

endmodule

/* hw/rtl/tlhg_back.sv */
// Back part of the latency guard: holds the tier and the counters, applies
// recovery hysteresis and drives the result register. Depends on tlhg_pkg.

module tlhg_back import tlhg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  tlhg_cmd_t          q_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TIER_W-1:0]  tier,
  output logic               escalated,
  output logic               recovered,
  output logic [COUNT_W-1:0] esc_total,
  output logic [COUNT_W-1:0] rec_total
);

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [TIER_W-1:0]  tier_r;
  logic [TIER_W-1:0]  tier_nxt;
  logic               esc_r;
  logic               esc_nxt;
  logic               rec_r;
  logic               rec_nxt;
  logic [COUNT_W-1:0] esc_cnt_r;
  logic [COUNT_W-1:0] esc_cnt_nxt;
  logic [COUNT_W-1:0] rec_cnt_r;
  logic [COUNT_W-1:0] rec_cnt_nxt;
  logic               take;
  logic               keep_cur;
  logic [TIER_W-1:0]  goal;

  assign take  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = take;

  always_comb begin
    case (tier_r)
      TIER_WARN:     keep_cur = q_cmd.keep[0];
      TIER_THROTTLE: keep_cur = q_cmd.keep[1];
      TIER_DROP:     keep_cur = q_cmd.keep[2];
      TIER_BREAKER:  keep_cur = q_cmd.keep[3];
      default:       keep_cur = 1'b1;
    endcase
  end

  // A fall is held back while the sample still clears the scaled level.
  assign goal = (q_cmd.target < tier_r && keep_cur) ? tier_r : q_cmd.target;

  always_comb begin
    out_valid_nxt = out_valid_r;
    tier_nxt      = tier_r;
    esc_nxt       = esc_r;
    rec_nxt       = rec_r;
    esc_cnt_nxt   = esc_cnt_r;
    rec_cnt_nxt   = rec_cnt_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      esc_nxt       = 1'b0;
      rec_nxt       = 1'b0;
      if (q_cmd.op == OP_CLEAR) begin
        tier_nxt = TIER_NORMAL;
      end else begin
        tier_nxt = goal;
        if (goal > tier_r) begin
          esc_nxt     = 1'b1;
          esc_cnt_nxt = esc_cnt_r + 1'b1;
        end else if (goal < tier_r) begin
          rec_nxt     = 1'b1;
          rec_cnt_nxt = rec_cnt_r + 1'b1;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tier_r      <= TIER_NORMAL;
      esc_r       <= 1'b0;
      rec_r       <= 1'b0;
      esc_cnt_r   <= '0;
      rec_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      tier_r      <= tier_nxt;
      esc_r       <= esc_nxt;
      rec_r       <= rec_nxt;
      esc_cnt_r   <= esc_cnt_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
    end
  end

  // Tier and counters change only with a new result, so they are the result.
  assign out_valid = out_valid_r;
  assign tier      = tier_r;
  assign escalated = esc_r;
  assign recovered = rec_r;
  assign esc_total = esc_cnt_r;
  assign rec_total = rec_cnt_r;

  // A result never both raises and lowers the tier.
  a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(esc_r && rec_r))
    else $error("escalated and recovered both set");

  // The escalation count moves exactly when a result reports an escalation.
  a_esc_count: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (esc_cnt_r != $past(esc_cnt_r)) == esc_r)
    else $error("escalation count out of step with flag");

endmodule

/* hw/rtl/tiered_latency_hysteresis_guard_core.sv */
// Top level of the tiered latency hysteresis guard: configuration registers
// and the front part, queue and back part. Depends on tlhg_pkg, tlhg_front,
// tlhg_queue and tlhg_back.
//
//  Channel   Direction  Payload
//  in_*      in         tuser: operation; tdata[31:0]: latency_sample
//  out_*     out        tdata: action_tier, escalated, recovered,
//                       escalation_total, recovery_total
//  cfg_*     in         write only: cfg_addr selects register, cfg_wdata value
//
// A request is accepted every cycle while the queue has room; it passes
// through the input register, loaded on the accepting edge, then the queue
// entry and then the result register. The sustained rate is one request per
// cycle while the output is not stalled, as the back part updates the tier
// for every request that it takes. rst_n is synchronous and
// active low; it empties the queue and restores the tier, counters and
// registers. A stalled output keeps its result while the front keeps filling
// the queue.

module tiered_latency_hysteresis_guard_core import tlhg_pkg::*; #(
  parameter int LATENCY_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // [0] operation
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [31:0] latency_sample
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] action_tier, [3] escalated, [4] recovered,
  // [36:5] escalation_total, [68:37] recovery_total, [71:69] zero
  output logic [71:0]           out_tdata,
  // Configuration write port.
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Samples and thresholds are taken modulo 2^LATENCY_WIDTH, but never
  // carry more than the 32 bits the ports bring in.
  localparam int LAT_W = (LATENCY_WIDTH < SAMPLE_W) ? LATENCY_WIDTH : SAMPLE_W;

  logic [NUM_LEVELS-1:0][LAT_W-1:0] thr_r;
  logic [NUM_LEVELS-1:0][LAT_W-1:0] thr_nxt;
  logic [SCALE_W-1:0]               scale_r;
  logic [SCALE_W-1:0]               scale_nxt;

  logic         f_valid;
  logic         q_not_full;
  logic         q_not_empty;
  logic         q_pop;
  tlhg_cmd_t    f_cmd;
  tlhg_cmd_t    head_cmd;

  logic [TIER_W-1:0]  tier;
  logic               escalated;
  logic               recovered;
  logic [COUNT_W-1:0] esc_total;
  logic [COUNT_W-1:0] rec_total;

  // Register decode; writes to indexes past the scale register are dropped.
  always_comb begin
    thr_nxt   = thr_r;
    scale_nxt = scale_r;
    if (cfg_wen) begin
      case (cfg_addr)
        REG_WARN:     thr_nxt[0] = cfg_wdata[LAT_W-1:0];
        REG_THROTTLE: thr_nxt[1] = cfg_wdata[LAT_W-1:0];
        REG_DROP:     thr_nxt[2] = cfg_wdata[LAT_W-1:0];
        REG_BREAKER:  thr_nxt[3] = cfg_wdata[LAT_W-1:0];
        REG_SCALE:    scale_nxt  = cfg_wdata[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0] <= RST_WARN[LAT_W-1:0];
      thr_r[1] <= RST_THROTTLE[LAT_W-1:0];
      thr_r[2] <= RST_DROP[LAT_W-1:0];
      thr_r[3] <= RST_BREAKER[LAT_W-1:0];
      scale_r  <= RST_SCALE;
    end else begin
      thr_r   <= thr_nxt;
      scale_r <= scale_nxt;
    end
  end

  // The front registers each request and compares it against all levels.
  tlhg_front #(
    .LAT_W (LAT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_lat   (in_tdata[LAT_W-1:0]),
    .thr      (thr_r),
    .scale    (scale_r),
    .q_valid  (f_valid),
    .q_ready  (q_not_full),
    .q_cmd    (f_cmd)
  );

  tlhg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_cmd  (f_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // The back applies hysteresis against the live tier and owns the result.
  tlhg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_cmd     (head_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .tier      (tier),
    .escalated (escalated),
    .recovered (recovered),
    .esc_total (esc_total),
    .rec_total (rec_total)
  );

  assign out_tdata = {3'b000, rec_total, esc_total, recovered, escalated, tier};

endmodule
